// ----- src/scs_pkg.sv -----
// Package for the sampling cycle sequencer: word types for the item and
// result channels, operation, stage, outcome and register index codes.
// No dependencies.
`default_nettype none

package scs_pkg;

  // Operation codes carried by an item word
  localparam logic [1:0] OpPoll  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpAbort = 2'd2;

  // Stage codes
  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StPreblow  = 4'd1;
  localparam logic [3:0] StGapA     = 4'd2;
  localparam logic [3:0] StLift     = 4'd3;
  localparam logic [3:0] StHold     = 4'd4;
  localparam logic [3:0] StMeter    = 4'd5;
  localparam logic [3:0] StGapB     = 4'd6;
  localparam logic [3:0] StPostblow = 4'd7;
  localparam logic [3:0] StDone     = 4'd8;
  localparam logic [3:0] StAborted  = 4'd9;

  // Outcome codes
  localparam logic [1:0] OutNone      = 2'd0;
  localparam logic [1:0] OutCompleted = 2'd1;
  localparam logic [1:0] OutAborted   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegBlowback = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLift     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHold     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRpm      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGap      = 3'd4;

  // Configuration reset values
  localparam logic [15:0] BlowbackReset = 16'd10;
  localparam logic [15:0] LiftReset     = 16'd30;
  localparam logic [15:0] HoldReset     = 16'd10;
  localparam logic [15:0] RpmReset      = 16'd100;
  localparam logic [15:0] GapReset      = 16'd500;

  typedef struct packed {
    logic [1:0]  operation;
    logic        bucket;
    logic        manual;
    logic [31:0] now_seconds;
    logic [31:0] now_millis;
  } scs_in_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  stage;
    logic        active;
    logic [1:0]  outcome;
    logic        inlet_valve;
    logic        lift_pump;
    logic        motor_on;
    logic        motor_reverse;
    logic [15:0] motor_speed;
    logic        bucket_in_use;
    logic        record_pulse;
    logic        record_automatic;
  } scs_out_t;

endpackage

`default_nettype wire

// ----- src/sampling_cycle_sequencer.sv -----
// Sampling cycle sequencer, top level and only module.
// Channels: item words in (in_*), result words out (out_*), register writes (cfg_*).
// Each item word carries an operation (poll, start, abort, or no-op) and the
// free-running second and millisecond counters. Every item yields exactly one
// result word with the drive levels, stage and outcome after that item.
// The result word is registered: it is valid the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; the stage update
// and the one elapsed-time subtract and compare per counter fit between the
// state registers and the result register.
// A poll advances at most one stage. Registers 0..3 are latched on start;
// the gap length is read live on every poll.
// Stall: the result register holds its word while out_ready_i is low, and
// in_ready_o drops only while that word is still waiting and not being taken.
// Reset: stage idle, outcome none, registers at their defaults, no result
// pending. cfg_ready_o is always high; writes to unknown indexes are dropped.
// Depends on scs_pkg.
`default_nettype none

module sampling_cycle_sequencer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,

  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire scs_pkg::scs_in_t           in_data_i,

  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      scs_pkg::scs_out_t          out_data_o,

  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [scs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                cfg_data_i
);

  // Configuration registers
  logic [15:0] blowback_q, lift_q, hold_q, rpm_q, gap_q;

  // Sequencer state
  logic [3:0]  stage_q, stage_d;
  logic        bucket_q, bucket_d;
  logic        manual_q, manual_d;
  logic [31:0] start_sec_q, start_sec_d;
  logic [31:0] gap_ms_q, gap_ms_d;
  logic [1:0]  outcome_q, outcome_d;
  logic [15:0] run_blow_q, run_blow_d;
  logic [15:0] run_lift_q, run_lift_d;
  logic [15:0] run_hold_q, run_hold_d;
  logic [15:0] run_rpm_q, run_rpm_d;

  // Result register
  logic              out_valid_q;
  scs_pkg::scs_out_t out_q, out_d;

  logic        in_fire;
  logic        running;
  logic        running_d;
  logic        accepted;
  logic        pulse;
  logic        motor;
  logic [15:0] sec_dur;
  logic [31:0] elapsed_sec;
  logic [31:0] elapsed_ms;
  logic        sec_done;
  logic        gap_done;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign running = (stage_q >= scs_pkg::StPreblow) && (stage_q <= scs_pkg::StPostblow);

  // Pick the second-based duration of the current stage
  always_comb begin
    unique case (stage_q)
      scs_pkg::StLift: sec_dur = run_lift_q;
      scs_pkg::StHold: sec_dur = run_hold_q;
      default:         sec_dur = run_blow_q;
    endcase
  end

  assign elapsed_sec = in_data_i.now_seconds - start_sec_q;
  assign elapsed_ms  = in_data_i.now_millis - gap_ms_q;
  assign sec_done    = elapsed_sec >= {16'd0, sec_dur};
  assign gap_done    = elapsed_ms >= {16'd0, gap_q};

  always_comb begin
    stage_d     = stage_q;
    bucket_d    = bucket_q;
    manual_d    = manual_q;
    start_sec_d = start_sec_q;
    gap_ms_d    = gap_ms_q;
    outcome_d   = outcome_q;
    run_blow_d  = run_blow_q;
    run_lift_d  = run_lift_q;
    run_hold_d  = run_hold_q;
    run_rpm_d   = run_rpm_q;
    accepted    = 1'b0;
    pulse       = 1'b0;

    unique case (in_data_i.operation)
      scs_pkg::OpStart: begin
        if (!running) begin
          bucket_d    = in_data_i.bucket;
          manual_d    = in_data_i.manual;
          run_blow_d  = blowback_q;
          run_lift_d  = lift_q;
          run_hold_d  = hold_q;
          run_rpm_d   = rpm_q;
          outcome_d   = scs_pkg::OutNone;
          stage_d     = scs_pkg::StPreblow;
          start_sec_d = in_data_i.now_seconds;
          accepted    = 1'b1;
        end
      end
      scs_pkg::OpAbort: begin
        if (running) begin
          outcome_d = scs_pkg::OutAborted;
          stage_d   = scs_pkg::StAborted;
        end
      end
      scs_pkg::OpPoll: begin
        unique case (stage_q)
          scs_pkg::StPreblow, scs_pkg::StMeter: begin
            // motor stage ends, start the millisecond gap
            if (sec_done) begin
              stage_d  = stage_q + 4'd1;
              gap_ms_d = in_data_i.now_millis;
            end
          end
          scs_pkg::StGapA, scs_pkg::StGapB: begin
            if (gap_done) begin
              stage_d     = stage_q + 4'd1;
              start_sec_d = in_data_i.now_seconds;
            end
          end
          scs_pkg::StLift, scs_pkg::StHold: begin
            if (sec_done) begin
              stage_d     = stage_q + 4'd1;
              start_sec_d = in_data_i.now_seconds;
            end
          end
          scs_pkg::StPostblow: begin
            if (sec_done) begin
              stage_d   = scs_pkg::StDone;
              outcome_d = scs_pkg::OutCompleted;
              pulse     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result word from the state after the item
  assign running_d = (stage_d >= scs_pkg::StPreblow) && (stage_d <= scs_pkg::StPostblow);
  assign motor     = (stage_d == scs_pkg::StPreblow) || (stage_d == scs_pkg::StMeter) ||
                     (stage_d == scs_pkg::StPostblow);

  always_comb begin
    out_d.accepted         = accepted;
    out_d.stage            = stage_d;
    out_d.active           = running_d;
    out_d.outcome          = outcome_d;
    out_d.inlet_valve      = running_d;
    out_d.lift_pump        = (stage_d == scs_pkg::StLift);
    out_d.motor_on         = motor;
    out_d.motor_reverse    = (stage_d == scs_pkg::StPreblow) || (stage_d == scs_pkg::StPostblow);
    out_d.motor_speed      = motor ? run_rpm_d : 16'd0;
    out_d.bucket_in_use    = bucket_d;
    out_d.record_pulse     = pulse;
    out_d.record_automatic = pulse && !manual_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blowback_q <= scs_pkg::BlowbackReset;
      lift_q     <= scs_pkg::LiftReset;
      hold_q     <= scs_pkg::HoldReset;
      rpm_q      <= scs_pkg::RpmReset;
      gap_q      <= scs_pkg::GapReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        scs_pkg::RegBlowback: blowback_q <= cfg_data_i;
        scs_pkg::RegLift:     lift_q     <= cfg_data_i;
        scs_pkg::RegHold:     hold_q     <= cfg_data_i;
        scs_pkg::RegRpm:      rpm_q      <= cfg_data_i;
        scs_pkg::RegGap:      gap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state, advance on every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= scs_pkg::StIdle;
      bucket_q    <= 1'b0;
      manual_q    <= 1'b0;
      start_sec_q <= 32'd0;
      gap_ms_q    <= 32'd0;
      outcome_q   <= scs_pkg::OutNone;
      run_blow_q  <= 16'd0;
      run_lift_q  <= 16'd0;
      run_hold_q  <= 16'd0;
      run_rpm_q   <= 16'd0;
    end else if (in_fire) begin
      stage_q     <= stage_d;
      bucket_q    <= bucket_d;
      manual_q    <= manual_d;
      start_sec_q <= start_sec_d;
      gap_ms_q    <= gap_ms_d;
      outcome_q   <= outcome_d;
      run_blow_q  <= run_blow_d;
      run_lift_q  <= run_lift_d;
      run_hold_q  <= run_hold_d;
      run_rpm_q   <= run_rpm_d;
    end
  end

  // Result valid: set on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the sampling cycle sequencer: drives item words,
// register writes and result backpressure, and predicts every result word.
// Depends on scs_pkg and sampling_cycle_sequencer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                  OpNop      = 2'd3;
  localparam logic [scs_pkg::CfgIdxW-1:0] RegUnused  = 3'd5;
  localparam int unsigned                 CycleLimit = 500_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  scs_pkg::scs_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  scs_pkg::scs_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [scs_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]                 cfg_data = '0;

  sampling_cycle_sequencer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies in the sequencer model
  logic [15:0] reg_blow = scs_pkg::BlowbackReset;
  logic [15:0] reg_lift = scs_pkg::LiftReset;
  logic [15:0] reg_hold = scs_pkg::HoldReset;
  logic [15:0] reg_rpm  = scs_pkg::RpmReset;
  logic [15:0] reg_gap  = scs_pkg::GapReset;

  // Cycle state in the sequencer model
  logic [3:0]  cur_stage = scs_pkg::StIdle;
  logic        cur_bucket = 1'b0;
  logic        cur_manual = 1'b0;
  logic [31:0] stage_sec_mark = '0;
  logic [31:0] gap_start_ms = '0;
  logic [1:0]  cur_outcome = scs_pkg::OutNone;
  logic [15:0] run_blow = '0;
  logic [15:0] run_lift = '0;
  logic [15:0] run_hold = '0;
  logic [15:0] run_rpm  = '0;

  scs_pkg::scs_in_t  pending_words[$];
  scs_pkg::scs_out_t expected_results[$];
  int       fail_count = 0;
  logic     word_taken = 1'b0;
  logic     no_idle = 1'b0;
  int       send_gap = 0;
  int       stall_left = 0;
  logic [31:0] gen_sec;
  logic [31:0] gen_ms;

  function automatic scs_pkg::scs_out_t sequencer_predict(scs_pkg::scs_in_t w);
    scs_pkg::scs_out_t r;
    logic [31:0] sec_elapsed;
    logic [31:0] ms_elapsed;
    logic        running;
    logic        pulse;
    logic        motor;
    r = '0;
    pulse = 1'b0;
    sec_elapsed = w.now_seconds - stage_sec_mark;
    ms_elapsed = w.now_millis - gap_start_ms;
    running = (cur_stage >= scs_pkg::StPreblow) && (cur_stage <= scs_pkg::StPostblow);
    case (w.operation)
      scs_pkg::OpStart: begin
        if (!running) begin
          cur_bucket = w.bucket;
          cur_manual = w.manual;
          run_blow = reg_blow;
          run_lift = reg_lift;
          run_hold = reg_hold;
          run_rpm = reg_rpm;
          cur_outcome = scs_pkg::OutNone;
          cur_stage = scs_pkg::StPreblow;
          stage_sec_mark = w.now_seconds;
          r.accepted = 1'b1;
        end
      end
      scs_pkg::OpAbort: begin
        if (running) begin
          cur_outcome = scs_pkg::OutAborted;
          cur_stage = scs_pkg::StAborted;
        end
      end
      scs_pkg::OpPoll: begin
        case (cur_stage)
          scs_pkg::StPreblow: if (sec_elapsed >= run_blow) begin
            cur_stage = scs_pkg::StGapA;
            gap_start_ms = w.now_millis;
          end
          scs_pkg::StGapA: if (ms_elapsed >= reg_gap) begin
            cur_stage = scs_pkg::StLift;
            stage_sec_mark = w.now_seconds;
          end
          scs_pkg::StLift: if (sec_elapsed >= run_lift) begin
            cur_stage = scs_pkg::StHold;
            stage_sec_mark = w.now_seconds;
          end
          scs_pkg::StHold: if (sec_elapsed >= run_hold) begin
            cur_stage = scs_pkg::StMeter;
            stage_sec_mark = w.now_seconds;
          end
          scs_pkg::StMeter: if (sec_elapsed >= run_blow) begin
            cur_stage = scs_pkg::StGapB;
            gap_start_ms = w.now_millis;
          end
          scs_pkg::StGapB: if (ms_elapsed >= reg_gap) begin
            cur_stage = scs_pkg::StPostblow;
            stage_sec_mark = w.now_seconds;
          end
          scs_pkg::StPostblow: if (sec_elapsed >= run_blow) begin
            cur_stage = scs_pkg::StDone;
            cur_outcome = scs_pkg::OutCompleted;
            pulse = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    running = (cur_stage >= scs_pkg::StPreblow) && (cur_stage <= scs_pkg::StPostblow);
    motor = (cur_stage == scs_pkg::StPreblow) || (cur_stage == scs_pkg::StMeter) ||
            (cur_stage == scs_pkg::StPostblow);
    r.stage = cur_stage;
    r.active = running;
    r.outcome = cur_outcome;
    r.inlet_valve = running;
    r.lift_pump = (cur_stage == scs_pkg::StLift);
    r.motor_on = motor;
    r.motor_reverse = (cur_stage == scs_pkg::StPreblow) || (cur_stage == scs_pkg::StPostblow);
    r.motor_speed = motor ? run_rpm : 16'd0;
    r.bucket_in_use = cur_bucket;
    r.record_pulse = pulse;
    r.record_automatic = pulse && !cur_manual;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Item word driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !word_taken) begin
        // hold the word until it is taken
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        send_gap = (!no_idle && $urandom_range(0, 9) < 4) ? pick_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left == 0 && !no_idle && $urandom_range(0, 4) == 0)
        stall_left = pick_len();
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted item word, check every taken result word
  always @(posedge clk) begin
    scs_pkg::scs_out_t want;
    word_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_results.push_back(sequencer_predict(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
          compare_field("stage", 32'(want.stage), 32'(out_data.stage));
          compare_field("active", 32'(want.active), 32'(out_data.active));
          compare_field("outcome", 32'(want.outcome), 32'(out_data.outcome));
          compare_field("inlet_valve", 32'(want.inlet_valve), 32'(out_data.inlet_valve));
          compare_field("lift_pump", 32'(want.lift_pump), 32'(out_data.lift_pump));
          compare_field("motor_on", 32'(want.motor_on), 32'(out_data.motor_on));
          compare_field("motor_reverse", 32'(want.motor_reverse),
                        32'(out_data.motor_reverse));
          compare_field("motor_speed", 32'(want.motor_speed), 32'(out_data.motor_speed));
          compare_field("bucket_in_use", 32'(want.bucket_in_use),
                        32'(out_data.bucket_in_use));
          compare_field("record_pulse", 32'(want.record_pulse), 32'(out_data.record_pulse));
          compare_field("record_automatic", 32'(want.record_automatic),
                        32'(out_data.record_automatic));
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_word(input logic [1:0] op, input logic bucket, input logic manual,
                           input logic [31:0] sec, input logic [31:0] ms);
    scs_pkg::scs_in_t w;
    w.operation = op;
    w.bucket = bucket;
    w.manual = manual;
    w.now_seconds = sec;
    w.now_millis = ms;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input logic [scs_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      scs_pkg::RegBlowback: reg_blow = value;
      scs_pkg::RegLift:     reg_lift = value;
      scs_pkg::RegHold:     reg_hold = value;
      scs_pkg::RegRpm:      reg_rpm = value;
      scs_pkg::RegGap:      reg_gap = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] blow, input logic [15:0] lift,
                               input logic [15:0] hold, input logic [15:0] rpm,
                               input logic [15:0] gap);
    write_reg(scs_pkg::RegBlowback, blow);
    write_reg(scs_pkg::RegLift, lift);
    write_reg(scs_pkg::RegHold, hold);
    write_reg(scs_pkg::RegRpm, rpm);
    write_reg(scs_pkg::RegGap, gap);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pause the sender until every expected result word has come
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly small steps, some mid-size, a few large enough to end the longest stages
  task automatic advance_counters();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      gen_sec += $urandom_range(0, 2);
      gen_ms += $urandom_range(0, 15);
    end else if (r < 90) begin
      gen_sec += $urandom_range(0, 12);
      gen_ms += $urandom_range(0, 600);
    end else begin
      gen_sec += $urandom_range(0, 32'h18000);
      gen_ms += $urandom_range(0, 32'h18000);
    end
  endtask

  task automatic run_random_phase(input int words);
    int          sent;
    int          polls;
    int unsigned r;
    logic [1:0]  op;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 3) == 0) begin
        push_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom, $urandom);
        sent++;
      end else begin
        gen_sec = $urandom;
        gen_ms = $urandom;
        push_word(scs_pkg::OpStart, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  gen_sec, gen_ms);
        sent++;
        polls = $urandom_range(10, 30);
        for (int i = 0; i < polls && sent < words; i++) begin
          advance_counters();
          r = $urandom_range(0, 99);
          if (r < 3) op = scs_pkg::OpStart;
          else if (r < 6) op = scs_pkg::OpAbort;
          else if (r < 9) op = OpNop;
          else op = scs_pkg::OpPoll;
          push_word(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gen_sec, gen_ms);
          sent++;
          if (op == scs_pkg::OpAbort) break;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] s;
    logic [31:0] m;
    logic [31:0] t;
    logic [31:0] u;
    logic [31:0] v;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle operations, a full cycle at default timing across counter
    // wrap, refused start, no-op, start from done and aborted, abort handling
    s = 32'hFFFF_FFFA;
    m = 32'hFFFF_FF00;
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, 32'h0, 32'h0);
    push_word(scs_pkg::OpAbort, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(OpNop, 1'b1, 1'b0, s, m);
    push_word(scs_pkg::OpStart, 1'b1, 1'b0, s, m);
    push_word(scs_pkg::OpStart, 1'b0, 1'b1, s + 1, m);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 9, m);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 10, m + 3);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 10, m + 502);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 11, m + 503);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 40, m + 600);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 41, m + 600);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 51, m + 650);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 61, m + 700);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 62, m + 1200);
    push_word(OpNop, 1'b0, 1'b1, s + 63, m + 1201);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 72, m + 1300);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, s + 90, m + 1400);
    t = 32'h8000_0000;
    push_word(scs_pkg::OpStart, 1'b0, 1'b1, t, 32'h7FFF_FFFF);
    push_word(scs_pkg::OpAbort, 1'b0, 1'b0, t + 1, 32'h7FFF_FFFF);
    push_word(scs_pkg::OpPoll, 1'b0, 1'b0, t + 100, 32'h8000_0000);
    push_word(scs_pkg::OpAbort, 1'b1, 1'b1, t + 101, 32'h8000_0000);
    push_word(scs_pkg::OpStart, 1'b1, 1'b1, t + 102, 32'h8000_0000);
    u = t + 102;
    v = 32'h8000_0000;
    // big steps end every stage on its first poll; the record is manual
    for (int i = 0; i < 7; i++) begin
      u += 100;
      v += 1000;
      push_word(scs_pkg::OpPoll, 1'b0, 1'b0, u, v);
    end

    wait_drained();
    apply_setting(16'd2, 16'd3, 16'd1, 16'($urandom), 16'd7);
    run_random_phase(155);

    wait_drained();
    no_idle = 1'b1;
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random_phase(155);

    wait_drained();
    no_idle = 1'b0;
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random_phase(155);

    for (int p = 0; p < 3; p++) begin
      wait_drained();
      no_idle = (p == 1);
      if (p == 2) write_reg(RegUnused, 16'($urandom));
      apply_setting(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                    16'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 40)));
      run_random_phase(155);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sampling_cycle_sequencer.f -----
src/scs_pkg.sv
src/sampling_cycle_sequencer.sv
tb/testbench.sv
